FILE: design/fbpa_pkg.sv
`timescale 1ns / 1ps

package fbpa_pkg;

   // Field widths of the request, response and register set.
   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 21;
   localparam int COUNT_W = 7;
   localparam int STAT_W  = 2;
   localparam int OIDX_W  = 6;
   localparam int CSR_W   = 2;

   // Flag memory rows hold 32 in-use flags each.
   localparam int ROW_BITS  = 32;
   localparam int BIT_SEL_W = 5;

   // Restoring divider, one quotient bit per step.
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = 6;

   // Request queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes.
   localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EXHAUSTED  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_MISALIGNED = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_RANGE      = 2'd3;

   // Register indexes.
   localparam logic [CSR_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_BLOCK_SIZE  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   // One classified request waiting in the queue.
   typedef struct packed {
      logic              opcode;
      logic              below_base;
      logic [ADDR_W-1:0] offset;
   } entry_type;

   // Register values as the back part uses them; block_size is never zero here.
   typedef struct packed {
      logic [ADDR_W-1:0]  pool_base;
      logic [SIZE_W-1:0]  block_size;
      logic [COUNT_W-1:0] block_count;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] dividend;
      logic [SIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] quotient;
      logic [SIZE_W-1:0] remainder;
   } div_rsp_type;

endpackage

FILE: design/fbpa_front.sv
`timescale 1ns / 1ps

module fbpa_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [fbpa_pkg::ADDR_W-1:0]  req_free_address,
   input  logic [fbpa_pkg::ADDR_W-1:0]  pool_base,
   output logic                         q_valid,
   output fbpa_pkg::entry_type          q_entry,
   input  logic                         q_pop
);

   fbpa_pkg::entry_type                entry_ff [fbpa_pkg::QUEUE_DEPTH];
   fbpa_pkg::entry_type                new_entry;
   logic [fbpa_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [fbpa_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [fbpa_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               push;
   logic                               pop;

   // Classify the request: flag an address below the base and form its offset.
   always_comb begin
      new_entry.opcode     = req_opcode;
      new_entry.below_base = req_free_address < pool_base;
      new_entry.offset     = req_free_address - pool_base;
   end

   assign req_stall = count_ff == fbpa_pkg::QCNT_W'(fbpa_pkg::QUEUE_DEPTH);
   assign push      = req_valid && !req_stall;
   assign q_valid   = count_ff != '0;
   assign pop       = q_pop && q_valid;
   assign q_entry   = entry_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

FILE: design/fbpa_divider.sv
`timescale 1ns / 1ps

module fbpa_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  fbpa_pkg::div_req_type   div_req,
   output fbpa_pkg::div_rsp_type   div_rsp
);

   logic [fbpa_pkg::ADDR_W-1:0]    quo_ff, quo_in;
   logic [fbpa_pkg::SIZE_W-1:0]    rem_ff, rem_in;
   logic [fbpa_pkg::SIZE_W-1:0]    dvs_ff, dvs_in;
   logic [fbpa_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [fbpa_pkg::SIZE_W:0]      trial;
   logic [fbpa_pkg::SIZE_W:0]      diff;

   // One restoring step: shift in the next dividend bit and try the subtract.
   assign trial = {rem_ff, quo_ff[fbpa_pkg::ADDR_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[fbpa_pkg::SIZE_W-1:0];
            quo_in = {quo_ff[fbpa_pkg::ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = trial[fbpa_pkg::SIZE_W-1:0];
            quo_in = {quo_ff[fbpa_pkg::ADDR_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == fbpa_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

FILE: design/fbpa_back.sv
`timescale 1ns / 1ps

module fbpa_back #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fbpa_pkg::cfg_type             cfg,
   input  logic                          q_valid,
   input  fbpa_pkg::entry_type           q_entry,
   output logic                          q_pop,
   output fbpa_pkg::div_req_type         div_req,
   input  fbpa_pkg::div_rsp_type         div_rsp,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fbpa_pkg::STAT_W-1:0]   rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]   rsp_block_address,
   output logic [fbpa_pkg::OIDX_W-1:0]   rsp_block_index
);

   localparam int ROWS   = (MAX_BLOCKS + fbpa_pkg::ROW_BITS - 1) / fbpa_pkg::ROW_BITS;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int FULL_W = ROW_W + fbpa_pkg::BIT_SEL_W;
   localparam int CNT_W  = FULL_W + 1;
   localparam int CMP_W  = (CNT_W > fbpa_pkg::COUNT_W) ? CNT_W : fbpa_pkg::COUNT_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ARD  = 3'd1;
   localparam logic [2:0] S_ACHK = 3'd2;
   localparam logic [2:0] S_AMUL = 3'd3;
   localparam logic [2:0] S_AADD = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_FRD  = 3'd6;
   localparam logic [2:0] S_FWR  = 3'd7;

   logic [2:0]                        state_ff, state_in;
   logic [ROW_W-1:0]                  row_ff, row_in;
   logic [FULL_W-1:0]                 idx_ff, idx_in;
   logic [fbpa_pkg::ADDR_W-1:0]       prod_ff, prod_in;
   logic [ROWS-1:0]                   row_valid_ff;
   logic [fbpa_pkg::ROW_BITS-1:0]     flag_mem [ROWS];
   logic [fbpa_pkg::ROW_BITS-1:0]     rd_data_ff;
   logic                              rd_row_valid_ff;
   logic [fbpa_pkg::ROW_BITS-1:0]     row_word;
   logic [fbpa_pkg::ROW_BITS-1:0]     avail;
   logic [fbpa_pkg::ROW_BITS-1:0]     free_mask;
   logic [fbpa_pkg::BIT_SEL_W-1:0]    free_sel;
   logic [fbpa_pkg::ROW_BITS-1:0]     sel_hot;
   logic [fbpa_pkg::ROW_BITS-1:0]     clr_hot;
   logic                              mem_we;
   logic [fbpa_pkg::ROW_BITS-1:0]     mem_wdata;
   logic [CMP_W-1:0]                  cnt_ext;
   logic [CMP_W-1:0]                  cnt_lim;
   logic [CNT_W-1:0]                  eff_cnt;
   logic                              out_valid_ff, out_valid_in;
   logic [fbpa_pkg::STAT_W-1:0]       out_status_ff, out_status_in;
   logic [fbpa_pkg::ADDR_W-1:0]       out_addr_ff, out_addr_in;
   logic [fbpa_pkg::OIDX_W-1:0]       out_idx_ff, out_idx_in;

   // Active block count, limited to the size of the pool.
   always_comb begin
      cnt_ext = CMP_W'(cfg.block_count);
      cnt_lim = CMP_W'(MAX_BLOCKS);
      eff_cnt = CNT_W'((cnt_ext > cnt_lim) ? cnt_lim : cnt_ext);
   end

   // A row never written since reset reads as all free.
   assign row_word = rd_row_valid_ff ? rd_data_ff : '0;

   // Blocks of the current row that lie inside the active pool.
   always_comb begin
      for (int b = 0; b < fbpa_pkg::ROW_BITS; b++) begin
         avail[b] = CNT_W'({row_ff, fbpa_pkg::BIT_SEL_W'(b)}) < eff_cnt;
      end
   end

   assign free_mask = ~row_word & avail;

   // Lowest free block of the row.
   always_comb begin
      free_sel = '0;
      for (int b = fbpa_pkg::ROW_BITS - 1; b >= 0; b--) begin
         if (free_mask[b]) begin
            free_sel = fbpa_pkg::BIT_SEL_W'(b);
         end
      end
   end

   assign sel_hot = fbpa_pkg::ROW_BITS'(1) << free_sel;
   assign clr_hot = fbpa_pkg::ROW_BITS'(1) << idx_ff[fbpa_pkg::BIT_SEL_W-1:0];

   // Request sequencer.
   always_comb begin
      state_in         = state_ff;
      row_in           = row_ff;
      idx_in           = idx_ff;
      prod_in          = prod_ff;
      q_pop            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = q_entry.offset;
      div_req.divisor  = cfg.block_size;
      mem_we           = 1'b0;
      mem_wdata        = row_word;
      out_valid_in     = out_valid_ff && rsp_stall;
      out_status_in    = out_status_ff;
      out_addr_in      = out_addr_ff;
      out_idx_in       = out_idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && !out_valid_ff) begin
               q_pop = 1'b1;
               if (q_entry.opcode == fbpa_pkg::OP_ALLOC) begin
                  row_in   = '0;
                  state_in = S_ARD;
               end else if (q_entry.below_base) begin
                  out_valid_in  = 1'b1;
                  out_status_in = fbpa_pkg::STATUS_RANGE;
                  out_addr_in   = '0;
                  out_idx_in    = '0;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_ARD: begin
            state_in = S_ACHK;
         end
         S_ACHK: begin
            if (free_mask != '0) begin
               mem_we    = 1'b1;
               mem_wdata = row_word | sel_hot;
               idx_in    = {row_ff, free_sel};
               state_in  = S_AMUL;
            end else if (row_ff == ROW_W'(ROWS - 1) || !avail[fbpa_pkg::ROW_BITS-1]) begin
               out_valid_in  = 1'b1;
               out_status_in = fbpa_pkg::STATUS_EXHAUSTED;
               out_addr_in   = '0;
               out_idx_in    = '0;
               state_in      = S_IDLE;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = S_ARD;
            end
         end
         S_AMUL: begin
            prod_in  = fbpa_pkg::ADDR_W'(idx_ff) * fbpa_pkg::ADDR_W'(cfg.block_size);
            state_in = S_AADD;
         end
         S_AADD: begin
            out_valid_in  = 1'b1;
            out_status_in = fbpa_pkg::STATUS_OK;
            out_addr_in   = cfg.pool_base + prod_ff;
            out_idx_in    = idx_ff[fbpa_pkg::OIDX_W-1:0];
            state_in      = S_IDLE;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder != '0) begin
                  out_valid_in  = 1'b1;
                  out_status_in = fbpa_pkg::STATUS_MISALIGNED;
                  out_addr_in   = '0;
                  out_idx_in    = '0;
                  state_in      = S_IDLE;
               end else if (div_rsp.quotient >= fbpa_pkg::ADDR_W'(eff_cnt)) begin
                  out_valid_in  = 1'b1;
                  out_status_in = fbpa_pkg::STATUS_RANGE;
                  out_addr_in   = '0;
                  out_idx_in    = '0;
                  state_in      = S_IDLE;
               end else begin
                  idx_in   = div_rsp.quotient[FULL_W-1:0];
                  row_in   = div_rsp.quotient[FULL_W-1:fbpa_pkg::BIT_SEL_W];
                  state_in = S_FRD;
               end
            end
         end
         S_FRD: begin
            state_in = S_FWR;
         end
         S_FWR: begin
            mem_we        = 1'b1;
            mem_wdata     = row_word & ~clr_hot;
            out_valid_in  = 1'b1;
            out_status_in = fbpa_pkg::STATUS_OK;
            out_addr_in   = '0;
            out_idx_in    = idx_ff[fbpa_pkg::OIDX_W-1:0];
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers; row valid bits stand in for clearing the flag memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (mem_we) begin
            row_valid_ff[row_ff] <= 1'b1;
         end
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      out_status_ff <= out_status_in;
      out_addr_ff   <= out_addr_in;
      out_idx_ff    <= out_idx_in;
   end

   // In-use flag memory, one row of flags per address, registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         flag_mem[row_ff] <= mem_wdata;
      end
      rd_data_ff <= flag_mem[row_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_row_valid_ff <= 1'b0;
      end else begin
         rd_row_valid_ff <= row_valid_ff[row_ff];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_block_address = out_addr_ff;
   assign rsp_block_index   = out_idx_ff;

endmodule

FILE: design/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    opcode, free_address
// rsp       out        rsp_valid/stall    status, block_address, block_index
// csr       in         csr_valid/ready    index, wdata
//
// A free runs its offset through the 32-step restoring divider before it answers;
// a misaligned or beyond-pool free answers after the divide, and a free below the base without it.
// An allocate reads and checks each 32-flag row in turn, then multiplies and adds, or answers exhausted.
// Reset clears the in-use flags at once through one valid bit per row; no clearing pass.
// A two-entry request queue keeps req flowing while a response waits on rsp_stall, until it fills.

module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [fbpa_pkg::ADDR_W-1:0]   req_free_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fbpa_pkg::STAT_W-1:0]   rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]   rsp_block_address,
   output logic [fbpa_pkg::OIDX_W-1:0]   rsp_block_index,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fbpa_pkg::CSR_W-1:0]    csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]   csr_wdata
);

   logic [fbpa_pkg::ADDR_W-1:0]   pool_base_ff;
   logic [fbpa_pkg::SIZE_W-1:0]   block_size_ff;
   logic [fbpa_pkg::COUNT_W-1:0]  block_count_ff;
   fbpa_pkg::cfg_type             cfg;
   logic                          q_valid;
   logic                          q_pop;
   fbpa_pkg::entry_type           q_entry;
   fbpa_pkg::div_req_type         div_req;
   fbpa_pkg::div_rsp_type         div_rsp;

   assign csr_ready = 1'b1;

   // Register set.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= '0;
         block_size_ff  <= fbpa_pkg::SIZE_W'(4096);
         block_count_ff <= fbpa_pkg::COUNT_W'(64);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fbpa_pkg::CSR_POOL_BASE: begin
               pool_base_ff <= csr_wdata;
            end
            fbpa_pkg::CSR_BLOCK_SIZE: begin
               block_size_ff <= csr_wdata[fbpa_pkg::SIZE_W-1:0];
            end
            fbpa_pkg::CSR_BLOCK_COUNT: begin
               block_count_ff <= csr_wdata[fbpa_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A block size of zero works as one.
   always_comb begin
      cfg.pool_base   = pool_base_ff;
      cfg.block_size  = (block_size_ff == '0) ? fbpa_pkg::SIZE_W'(1) : block_size_ff;
      cfg.block_count = block_count_ff;
   end

   fbpa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_free_address (req_free_address),
      .pool_base        (pool_base_ff),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop)
   );

   fbpa_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   fbpa_back #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .q_pop             (q_pop),
      .div_req           (div_req),
      .div_rsp           (div_rsp),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_block_index   (rsp_block_index)
   );

endmodule
